// File: sv/ter_pkg.sv
// ----------------------------------------------------------------------------
// ter_pkg: shared type for the tetrahedron edge ratio pipeline
// Cell control word.
// ----------------------------------------------------------------------------
package ter_pkg;

  // request tag that travels with each stage
  typedef struct packed {
    logic vld;
    logic degen;
    logic eq;
  } cell_ctl_t;

endpackage

// File: sv/ter_div_cell.sv
// ----------------------------------------------------------------------------
// ter_div_cell: one restoring-division step
// Shifts the partial remainder, subtracts the divisor if it fits, takes a
// quotient bit, and hands the result to the next cell.
// ----------------------------------------------------------------------------
module ter_div_cell #(
  parameter int SQ_W = 35,
  parameter int Q_W  = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ter_pkg::cell_ctl_t   ctl_i,
  input  logic [SQ_W-1:0]      rem_i,
  input  logic [SQ_W-1:0]      div_i,
  input  logic [Q_W-1:0]       q_i,
  output ter_pkg::cell_ctl_t   ctl_o,
  output logic [SQ_W-1:0]      rem_o,
  output logic [SQ_W-1:0]      div_o,
  output logic [Q_W-1:0]       q_o
);

  logic [SQ_W:0] sh;
  logic [SQ_W:0] df;
  logic          ge;

  always_comb begin
    sh = {rem_i, 1'b0};
    df = sh - {1'b0, div_i};
    ge = (sh >= {1'b0, div_i});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? df[SQ_W-1:0] : sh[SQ_W-1:0];
      div_o <= div_i;
      q_o   <= {q_i[Q_W-2:0], ge};
    end
  end

endmodule

// File: sv/ter_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ter_sqrt_cell: one digit step of the integer square root
// Brings down two radicand bits, tries the next root bit, passes on.
// ----------------------------------------------------------------------------
module ter_sqrt_cell #(
  parameter int Q_W = 33,
  parameter int R_W = 17
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  ter_pkg::cell_ctl_t ctl_i,
  input  logic [Q_W-1:0]     rad_i,
  input  logic [R_W+1:0]     rem_i,
  input  logic [R_W-1:0]     root_i,
  output ter_pkg::cell_ctl_t ctl_o,
  output logic [Q_W-1:0]     rad_o,
  output logic [R_W+1:0]     rem_o,
  output logic [R_W-1:0]     root_o
);

  logic [R_W+3:0] tr;
  logic [R_W+3:0] tst;
  logic [R_W+3:0] dif;
  logic           ge;

  always_comb begin
    tr  = {rem_i, rad_i[Q_W-1 -: 2]};
    tst = {2'b00, root_i, 2'b01};
    dif = tr - tst;
    ge  = (tr >= tst);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[Q_W-3:0], 2'b00};
      rem_o  <= ge ? dif[R_W+1:0] : tr[R_W+1:0];
      root_o <= {root_i[R_W-2:0], ge};
    end
  end

endmodule

// File: sv/tet_edge_ratio.sv
// ----------------------------------------------------------------------------
// tet_edge_ratio: shortest over longest edge of a tetrahedron
// Edge lengths squared, min/max, a chain of division cells, then a chain
// of square-root cells.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the output is not stalled; set by the one-step-per-cell chains.
// The whole pipe advances when the output is free or being taken.
// Reset clears the valid bits of every stage; data registers are not reset.
module tet_edge_ratio #(
  parameter int COORD_WIDTH     = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [COORD_WIDTH-1:0]      ax, ay, az,
  input  logic [COORD_WIDTH-1:0]      bx, by_coord, bz,
  input  logic [COORD_WIDTH-1:0]      cx, cy, cz,
  input  logic [COORD_WIDTH-1:0]      dx, dy, dz,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [RATIO_FRAC_BITS:0]    ratio,
  output logic                        degenerate
);

  localparam int DW   = COORD_WIDTH;
  localparam int PW   = 2 * DW;
  localparam int SQ_W = PW + 2;
  localparam int NDIV = 2 * RATIO_FRAC_BITS;
  localparam int Q_W  = NDIV + 2;
  localparam int R_W  = RATIO_FRAC_BITS + 1;
  localparam int NSQ  = Q_W / 2;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // edge stages: per-axis absolute differences of every edge, their squares, then squared edge lengths
  logic [COORD_WIDTH-1:0] p [4][3];
  assign p[0] = '{ax, ay, az};
  assign p[1] = '{bx, by_coord, bz};
  assign p[2] = '{cx, cy, cz};
  assign p[3] = '{dx, dy, dz};

  localparam int EA [6] = '{0, 0, 0, 1, 2, 1};
  localparam int EB [6] = '{1, 2, 3, 2, 3, 3};

  logic       s1_vld;
  logic [DW-1:0] d1 [6][3];
  logic       s2_vld;
  logic [PW-1:0] m2 [6][3];
  logic       s3_vld;
  logic [SQ_W-1:0] e3 [6];
  logic       s4_vld;
  logic [SQ_W-1:0] lo4, hi4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        for (int k = 0; k < 3; k++) begin
          logic signed [DW:0] a, b, df;
          a  = {p[EA[i]][k][DW-1], p[EA[i]][k]};
          b  = {p[EB[i]][k][DW-1], p[EB[i]][k]};
          df = a - b;
          d1[i][k] <= df[DW] ? DW'(-df) : df[DW-1:0];
        end
      end
      for (int i = 0; i < 6; i++)
        for (int k = 0; k < 3; k++)
          m2[i][k] <= d1[i][k] * d1[i][k];
      for (int i = 0; i < 6; i++)
        e3[i] <= SQ_W'(m2[i][0]) + SQ_W'(m2[i][1]) + SQ_W'(m2[i][2]);
    end
  end

  // min/max over all edges
  logic [SQ_W-1:0] lo_c, hi_c;
  always_comb begin
    lo_c = e3[0];
    hi_c = e3[0];
    for (int i = 1; i < 6; i++) begin
      if (e3[i] < lo_c) lo_c = e3[i];
      if (e3[i] > hi_c) hi_c = e3[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo4 <= lo_c;
      hi4 <= hi_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
    end
  end

  // division chain
  ter_pkg::cell_ctl_t dctl [NDIV+1];
  logic [SQ_W-1:0]    drem [NDIV+1];
  logic [SQ_W-1:0]    ddiv [NDIV+1];
  logic [Q_W-1:0]     dq   [NDIV+1];

  assign dctl[0] = '{vld: s4_vld, degen: (hi4 == '0), eq: (lo4 == hi4)};
  assign drem[0] = lo4;
  assign ddiv[0] = hi4;
  assign dq[0]   = '0;

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    ter_div_cell #(.SQ_W(SQ_W), .Q_W(Q_W)) u_cell (
      .clk, .rst, .en,
      .ctl_i(dctl[g]), .rem_i(drem[g]), .div_i(ddiv[g]), .q_i(dq[g]),
      .ctl_o(dctl[g+1]), .rem_o(drem[g+1]), .div_o(ddiv[g+1]), .q_o(dq[g+1])
    );
  end

  // square-root chain; equal nonzero edges give exactly 1.0
  ter_pkg::cell_ctl_t sctl [NSQ+1];
  logic [Q_W-1:0]     srad [NSQ+1];
  logic [R_W+1:0]     srem [NSQ+1];
  logic [R_W-1:0]     sroot[NSQ+1];

  assign sctl[0]  = dctl[NDIV];
  assign srad[0]  = dctl[NDIV].eq ? (Q_W'(1) << NDIV) : dq[NDIV];
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    ter_sqrt_cell #(.Q_W(Q_W), .R_W(R_W)) u_cell (
      .clk, .rst, .en,
      .ctl_i(sctl[g]), .rad_i(srad[g]), .rem_i(srem[g]), .root_i(sroot[g]),
      .ctl_o(sctl[g+1]), .rad_o(srad[g+1]), .rem_o(srem[g+1]), .root_o(sroot[g+1])
    );
  end

  assign out_valid  = sctl[NSQ].vld;
  assign degenerate = sctl[NSQ].degen;
  assign ratio      = sctl[NSQ].degen ? '0 : sroot[NSQ];

  // a stalled result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ratio))
    else $error("result changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> ratio == '0)
    else $error("degenerate with nonzero ratio");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ratio <= (R_W'(1) << RATIO_FRAC_BITS))
    else $error("ratio above one");

endmodule

// File: tb/sv/tb_tet_edge_ratio.sv
// ----------------------------------------------------------------------------
// tb_tet_edge_ratio: self-checking bench for the tetrahedron edge ratio block
// Directed and random tetrahedra are driven with random idle bursts on both
// sides; each result is checked against a bit-exact predictor of the ratio.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tet_edge_ratio;

  localparam int CW        = 16;
  localparam int FB        = 16;
  localparam int LATENCY   = 4 + 2*FB + FB + 1;
  localparam int N_RANDOM  = 830;
  localparam int CYCLE_MAX = 200000;

  typedef struct {
    logic [CW-1:0] c[12];
  } tet_t;

  typedef struct {
    logic [FB:0] ratio;
    logic        degen;
  } ratio_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CW-1:0] pin[12];
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FB:0] ratio;
  logic degenerate;

  tet_t   pending_q[$];
  ratio_t expected_q[$];
  int errors = 0;
  int checked = 0;
  int degen_seen = 0;
  int cycles = 0;
  bit stim_done = 0;
  bit quiet = 0;
  bit in_taken = 0;
  int in_gap = 0;
  int out_gap = 0;

  initial for (int i = 0; i < 12; i++) pin[i] = '0;

  tet_edge_ratio dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .ax(pin[0]), .ay(pin[1]), .az(pin[2]),
    .bx(pin[3]), .by_coord(pin[4]), .bz(pin[5]),
    .cx(pin[6]), .cy(pin[7]), .cz(pin[8]),
    .dx(pin[9]), .dy(pin[10]), .dz(pin[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .ratio(ratio), .degenerate(degenerate)
  );

  always #1 clk = ~clk;

  function automatic logic [33:0] edge_len_sq(tet_t t, int p, int q);
    logic [33:0] s;
    logic signed [33:0] d;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      d = $signed({t.c[p*3+k][CW-1], t.c[p*3+k]}) - $signed({t.c[q*3+k][CW-1], t.c[q*3+k]});
      s += 34'(d * d);
    end
    return s;
  endfunction

  function automatic ratio_t calc_ratio(tet_t t);
    int ends[6][2] = '{'{0,1}, '{0,2}, '{0,3}, '{1,2}, '{2,3}, '{1,3}};
    logic [33:0] lo, hi, e;
    logic [65:0] quo;
    logic [63:0] qv, root;
    ratio_t r;
    lo = edge_len_sq(t, 0, 1);
    hi = lo;
    for (int i = 1; i < 6; i++) begin
      e = edge_len_sq(t, ends[i][0], ends[i][1]);
      if (e < lo) lo = e;
      if (e > hi) hi = e;
    end
    r.degen = (hi == 0);
    r.ratio = '0;
    if (hi != 0) begin
      quo = ({32'd0, lo} << (2*FB)) / {32'd0, hi};
      qv = quo[63:0];
      // bitwise integer square root
      root = 0;
      for (int b = 31; b >= 0; b--)
        if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= qv) root |= 64'd1 << b;
      r.ratio = root[FB:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic tet_t rand_tet(int mode);
    tet_t t;
    int base, span;
    for (int i = 0; i < 12; i++) t.c[i] = CW'($urandom);
    case (mode)
      0: ;
      1: begin
        // small tetrahedron near a random point, gives ratios across the range
        span = $urandom_range(1, 600);
        for (int k = 0; k < 3; k++) begin
          base = $urandom_range(0, 60000) - 30000;
          for (int p = 0; p < 4; p++)
            t.c[p*3+k] = CW'(base + $urandom_range(0, span) - span/2);
        end
      end
      2: begin
        // some corners coincide
        int src = $urandom_range(0, 3);
        for (int p = 0; p < 4; p++)
          if ($urandom_range(0, 1))
            for (int k = 0; k < 3; k++) t.c[p*3+k] = t.c[src*3+k];
      end
      default: for (int i = 0; i < 12; i++) t.c[i] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    endcase
    return t;
  endfunction

  task automatic push(tet_t t);
    pending_q.push_back(t);
  endtask

  initial begin
    tet_t t;
    for (int i = 0; i < 12; i++) t.c[i] = '0;
    push(t);                                      // all corners equal
    for (int i = 0; i < 12; i++) t.c[i] = 16'h8000;
    push(t);
    for (int i = 0; i < 12; i++) t.c[i] = 16'h7fff;
    push(t);
    // regular tetrahedron: all edges equal
    t.c = '{16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'hff00, 16'hff00,
            16'hff00, 16'h0100, 16'hff00, 16'hff00, 16'hff00, 16'h0100};
    push(t);
    // extreme corners
    t.c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
            16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
    push(t);
    t.c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
            16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000};
    push(t);
    // one zero edge only
    t.c = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000};
    push(t);
    // tiny edge against a huge one
    t.c = '{16'h8000, 16'h8000, 16'h8000, 16'h8001, 16'h8000, 16'h8000,
            16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7ffe, 16'h7fff};
    push(t);
    for (int i = 0; i < 12; i++) t.c[i] = 16'hffff;
    t.c[11] = 16'h0000;
    push(t);
    for (int i = 0; i < 8; i++) push(rand_tet(3));
    for (int i = 0; i < 6; i++) push(rand_tet(2));
    for (int i = 0; i < N_RANDOM; i++) begin
      int m;
      m = $urandom_range(0, 9);
      push(rand_tet(m < 3 ? 0 : m < 8 ? 1 : m < 9 ? 2 : 3));
    end
  end

  // driver; in_taken tells whether the request was accepted at the last rising edge
  always @(negedge clk) begin
    if (!rst) begin
      quiet <= (pending_q.size() < 80);
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          in_gap <= $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          tet_t t;
          t = pending_q.pop_front();
          for (int i = 0; i < 12; i++) pin[i] <= t.c[i];
          expected_q.push_back(calc_ratio(t));
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap <= $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      ratio_t w;
      if (expected_q.size() == 0) begin
        report("unexpected result", 32'(ratio), 32'(0));
      end else begin
        w = expected_q.pop_front();
        if (ratio !== w.ratio) report("ratio", 32'(ratio), 32'(w.ratio));
        if (degenerate !== w.degen) report("degenerate", 32'(degenerate), 32'(w.degen));
        checked++;
        if (w.degen) degen_seen++;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    fork
      begin
        wait (stim_done && expected_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
      end
      begin
        wait (cycles >= CYCLE_MAX);
        $display("timeout after %0d cycles", cycles);
        $display("FAIL tet_edge_ratio");
        $finish;
      end
    join_any
    $display("checked %0d edge ratios, %0d degenerate", checked, degen_seen);
    $display("directed corners, extremes, coincident points and random tetrahedra");
    if (errors == 0) begin
      $display("PASS tet_edge_ratio");
    end else begin
      $display("FAIL tet_edge_ratio");
    end
    $finish;
  end

endmodule
